@@ sv/stereo_to_five_channel_fir_mixer_top_assert.svh @@
// ----------------------------------------------------------------------------
// stereo to five-channel mixer: assertion macros
// shared property shapes, clocked on aclk and held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef STEREO_TO_FIVE_CHANNEL_FIR_MIXER_TOP_ASSERT_SVH
`define STEREO_TO_FIVE_CHANNEL_FIR_MIXER_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define STFM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define STFM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/stfm_pkg.sv @@
// ----------------------------------------------------------------------------
// stfm_pkg
// widths, codes, reset values and shared types of the stereo to five-channel
// mixer
// ----------------------------------------------------------------------------
package stfm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = SAMPLE_W - 1;
    localparam int TAPS_DEF   = 64;
    localparam int OPCODE_W   = 2;
    localparam int TAP_IDX_W  = 6;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 15;
    localparam int LIMIT_W    = 23;
    localparam int ACC_W      = 64;
    localparam int GPROD_W    = SAMPLE_W + GAIN_W + 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam int S_FIELD_BITS = TAP_IDX_W + 3 * SAMPLE_W;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 5 * SAMPLE_W;
    localparam int M_TDATA_W    = ((M_FIELD_BITS + 7) / 8) * 8;

    // item kinds carried on tuser
    localparam logic [OPCODE_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_HP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_LP = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_LEVEL = 3'd4;

    // 0.7071 in Q1.15 and 0.999 in Q0.23
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd23170;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 23'd8380219;

    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< FRAC_W) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef struct packed {
        logic push;
        logic hp_we;
        logic lp_we;
    } fir_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fir_stat_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        begin
            t = v;
            if (t > SAT_HI) begin
                t = SAT_HI;
            end else if (t < SAT_LO) begin
                t = SAT_LO;
            end
            return t[SAMPLE_W-1:0];
        end
    endfunction

endpackage

@@ sv/stfm_fir_engine.sv @@
// ----------------------------------------------------------------------------
// stfm_fir_engine
// both fir filters over one shared delay memory and one coefficient memory,
// one multiply-accumulate per tap and channel per cycle
// ----------------------------------------------------------------------------
module stfm_fir_engine
    import stfm_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fir_ctrl_t                  ctrl,
    input  logic [$clog2(TAPS)-1:0]    coef_addr,
    input  logic signed [SAMPLE_W-1:0] coef_data,
    input  logic signed [SAMPLE_W-1:0] x_hp,
    input  logic signed [SAMPLE_W-1:0] x_lp,
    output fir_stat_t                  stat,
    output logic signed [SAMPLE_W-1:0] y_hp,
    output logic signed [SAMPLE_W-1:0] y_lp
);

    localparam int TAP_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int PAIR_W = 2 * SAMPLE_W;
    localparam logic [TAP_W-1:0]  LAST_TAP  = TAP_W'(TAPS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (FRAC_W - 1);

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_MAC   = 2'd1;
    localparam logic [1:0] E_DRAIN = 2'd2;
    localparam logic [1:0] E_ROUND = 2'd3;

    logic [PAIR_W-1:0] coef_mem [TAPS];
    logic [PAIR_W-1:0] dly_mem  [TAPS];

    logic [1:0]        est_reg;
    logic [TAP_W-1:0]  tap_reg;
    logic [TAP_W-1:0]  head_reg;
    logic [TAP_W-1:0]  age_addr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [TAPS-1:0]   hp_ok_reg;
    logic [TAPS-1:0]   lp_ok_reg;
    logic              rd_vld_reg;
    logic              mul_vld_reg;
    logic              done_reg;

    logic [PAIR_W-1:0]        coef_rd_reg;
    logic [PAIR_W-1:0]        dly_rd_reg;
    logic                     hp_use_reg;
    logic                     lp_use_reg;
    logic signed [PROD_W-1:0] prod_hp_reg;
    logic signed [PROD_W-1:0] prod_lp_reg;
    logic signed [ACC_W-1:0]  acc_hp_reg;
    logic signed [ACC_W-1:0]  acc_lp_reg;
    logic signed [SAMPLE_W-1:0] y_hp_reg;
    logic signed [SAMPLE_W-1:0] y_lp_reg;

    logic [TAP_W-1:0]  head_inc;
    logic [TAP_W-1:0]  age_dec;
    logic              age_ok;
    logic signed [SAMPLE_W-1:0] hp_a;
    logic signed [SAMPLE_W-1:0] hp_b;
    logic signed [SAMPLE_W-1:0] lp_a;
    logic signed [SAMPLE_W-1:0] lp_b;

    function automatic logic signed [SAMPLE_W-1:0] round_acc(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] t;
        begin
            t = acc + ACC_RND;
            t = t >>> FRAC_W;
            return sat_sample(t);
        end
    endfunction

    assign head_inc = (head_reg == LAST_TAP) ? '0 : head_reg + 1'b1;
    assign age_dec  = (age_addr_reg == '0) ? LAST_TAP : age_addr_reg - 1'b1;
    // entries older than the number of pushes since reset still read as zero
    assign age_ok   = FILL_W'(tap_reg) < fill_reg;

    assign hp_a = hp_use_reg ? $signed(coef_rd_reg[SAMPLE_W-1:0]) : '0;
    assign hp_b = $signed(dly_rd_reg[SAMPLE_W-1:0]);
    assign lp_a = lp_use_reg ? $signed(coef_rd_reg[PAIR_W-1:SAMPLE_W]) : '0;
    assign lp_b = $signed(dly_rd_reg[PAIR_W-1:SAMPLE_W]);

    // coefficient memory, one half per filter
    always_ff @(posedge aclk) begin
        if (ctrl.hp_we) begin
            coef_mem[coef_addr][SAMPLE_W-1:0] <= coef_data;
        end
        if (ctrl.lp_we) begin
            coef_mem[coef_addr][PAIR_W-1:SAMPLE_W] <= coef_data;
        end
        coef_rd_reg <= coef_mem[tap_reg];
    end

    // delay memory as a ring, newest sample at head_reg; the push is written in
    // the cycle before the first read so no forwarding is needed
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            dly_mem[head_inc] <= {x_lp, x_hp};
        end
        dly_rd_reg <= dly_mem[age_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg     <= E_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            hp_ok_reg   <= '0;
            lp_ok_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg    <= 1'b0;
            rd_vld_reg  <= (est_reg == E_MAC);
            mul_vld_reg <= rd_vld_reg;
            if (ctrl.hp_we) begin
                hp_ok_reg[coef_addr] <= 1'b1;
            end
            if (ctrl.lp_we) begin
                lp_ok_reg[coef_addr] <= 1'b1;
            end
            unique case (est_reg)
                E_IDLE: begin
                    if (ctrl.push) begin
                        head_reg     <= head_inc;
                        age_addr_reg <= head_inc;
                        tap_reg      <= '0;
                        if (fill_reg != FILL_FULL) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        est_reg <= E_MAC;
                    end
                end
                E_MAC: begin
                    tap_reg      <= tap_reg + 1'b1;
                    age_addr_reg <= age_dec;
                    if (tap_reg == LAST_TAP) begin
                        est_reg <= E_DRAIN;
                    end
                end
                E_DRAIN: begin
                    if (!rd_vld_reg && !mul_vld_reg) begin
                        est_reg <= E_ROUND;
                    end
                end
                E_ROUND: begin
                    done_reg <= 1'b1;
                    est_reg  <= E_IDLE;
                end
                default: begin
                    est_reg <= E_IDLE;
                end
            endcase
        end
    end

    // read, multiply, accumulate
    always_ff @(posedge aclk) begin
        hp_use_reg  <= hp_ok_reg[tap_reg] & age_ok;
        lp_use_reg  <= lp_ok_reg[tap_reg] & age_ok;
        prod_hp_reg <= hp_a * hp_b;
        prod_lp_reg <= lp_a * lp_b;
        if (ctrl.push) begin
            acc_hp_reg <= '0;
            acc_lp_reg <= '0;
        end else if (mul_vld_reg) begin
            acc_hp_reg <= acc_hp_reg + ACC_W'(prod_hp_reg);
            acc_lp_reg <= acc_lp_reg + ACC_W'(prod_lp_reg);
        end
        if (est_reg == E_ROUND) begin
            y_hp_reg <= round_acc(acc_hp_reg);
            y_lp_reg <= round_acc(acc_lp_reg);
        end
    end

    assign stat.busy = (est_reg != E_IDLE);
    assign stat.done = done_reg;
    assign y_hp      = y_hp_reg;
    assign y_lp      = y_lp_reg;

endmodule

@@ sv/stereo_to_five_channel_fir_mixer_top.sv @@
// ----------------------------------------------------------------------------
// stereo_to_five_channel_fir_mixer_top
// One stereo pair in, five channels out. A sample beat is gained and clipped
// per channel, then in filter mode runs through a high-pass fir (left) and a
// low-pass fir (right) of TAPS taps each; the block takes one item at a time.
// A filtered sample goes from acceptance to the result register through the
// single multiply-accumulate pass that walks the delay and coefficient
// memories one tap per cycle. Bypass and disabled samples skip that pass;
// coefficient load beats give no result. The next beat is taken while a
// result still waits in the output register.
// Filter state is ready straight after reset: valid bits and a fill count make
// unwritten memory entries read as zero, so there is no clearing pass.
// ----------------------------------------------------------------------------
`include "stereo_to_five_channel_fir_mixer_top_assert.svh"

module stereo_to_five_channel_fir_mixer_top
    import stfm_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tap_index, coef_value, left_sample, right_sample, zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [OPCODE_W-1:0]    s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_left, out_right, out_left_surround, out_right_surround, out_center
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int TAP_W = $clog2(TAPS);
    localparam logic signed [GPROD_W-1:0] GAIN_RND = GPROD_W'(1) <<< (GAIN_FRAC - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GAIN   = 3'd1;
    localparam logic [2:0] ST_CLIP   = 3'd2;
    localparam logic [2:0] ST_FIR    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]         state_reg;
    logic               enable_reg;
    logic               filter_mode_reg;
    logic [GAIN_W-1:0]  gain_left_reg;
    logic [GAIN_W-1:0]  gain_right_reg;
    logic [LIMIT_W-1:0] limit_level_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic signed [SAMPLE_W-1:0] l_raw_reg;
    logic signed [SAMPLE_W-1:0] r_raw_reg;
    logic signed [GPROD_W-1:0]  gp_l_reg;
    logic signed [GPROD_W-1:0]  gp_r_reg;
    logic signed [SAMPLE_W-1:0] ls_reg;
    logic signed [SAMPLE_W-1:0] rs_reg;

    logic [TAP_IDX_W-1:0]       in_tap;
    logic signed [SAMPLE_W-1:0] in_coef;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic                       s_beat;
    logic                       tap_ok;
    logic                       out_free;
    logic                       run_fir;
    logic signed [SAMPLE_W-1:0] ls_c;
    logic signed [SAMPLE_W-1:0] rs_c;
    logic signed [SAMPLE_W-1:0] out_l_c;
    logic signed [SAMPLE_W-1:0] out_r_c;
    logic signed [SAMPLE_W-1:0] out_ls_c;
    logic signed [SAMPLE_W-1:0] out_rs_c;
    logic signed [SAMPLE_W-1:0] out_c_c;
    logic signed [ACC_W-1:0]    center_sum;

    fir_ctrl_t                  fir_ctrl;
    fir_stat_t                  fir_stat;
    logic signed [SAMPLE_W-1:0] y_hp;
    logic signed [SAMPLE_W-1:0] y_lp;

    function automatic logic signed [SAMPLE_W-1:0] gain_clip(
        input logic signed [GPROD_W-1:0] p,
        input logic [LIMIT_W-1:0]        lim
    );
        logic signed [GPROD_W-1:0] v;
        logic signed [GPROD_W-1:0] hi;
        logic signed [GPROD_W-1:0] lo;
        begin
            v  = p + GAIN_RND;
            v  = v >>> GAIN_FRAC;
            hi = $signed(GPROD_W'(lim));
            lo = -hi;
            if (v > hi) begin
                v = hi;
            end else if (v < lo) begin
                v = lo;
            end
            return v[SAMPLE_W-1:0];
        end
    endfunction

    assign in_tap   = s_tdata[TAP_IDX_W-1:0];
    assign in_coef  = $signed(s_tdata[TAP_IDX_W +: SAMPLE_W]);
    assign in_left  = $signed(s_tdata[TAP_IDX_W + SAMPLE_W +: SAMPLE_W]);
    assign in_right = $signed(s_tdata[TAP_IDX_W + 2 * SAMPLE_W +: SAMPLE_W]);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign tap_ok   = int'(in_tap) < TAPS;
    assign out_free = !m_tvalid_reg || m_tready;
    assign run_fir  = enable_reg && filter_mode_reg;

    assign ls_c = gain_clip(gp_l_reg, limit_level_reg);
    assign rs_c = gain_clip(gp_r_reg, limit_level_reg);

    assign fir_ctrl.push  = (state_reg == ST_CLIP) && run_fir;
    assign fir_ctrl.hp_we = s_beat && (s_tuser == OP_LOAD_HP) && tap_ok;
    assign fir_ctrl.lp_we = s_beat && (s_tuser == OP_LOAD_LP) && tap_ok;

    stfm_fir_engine #(
        .TAPS (TAPS)
    ) u_fir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fir_ctrl),
        .coef_addr (TAP_W'(in_tap)),
        .coef_data (in_coef),
        .x_hp      (ls_c),
        .x_lp      (rs_c),
        .stat      (fir_stat),
        .y_hp      (y_hp),
        .y_lp      (y_lp)
    );

    // output selection; disabled passes the raw pair and zeroes the rest
    always_comb begin
        if (!enable_reg) begin
            out_l_c = l_raw_reg;
            out_r_c = r_raw_reg;
        end else if (filter_mode_reg) begin
            out_l_c = y_hp;
            out_r_c = y_lp;
        end else begin
            out_l_c = ls_reg;
            out_r_c = rs_reg;
        end
        center_sum = ACC_W'(out_l_c) + ACC_W'(out_r_c);
        out_ls_c   = enable_reg ? ls_reg : '0;
        out_rs_c   = enable_reg ? rs_reg : '0;
        out_c_c    = enable_reg ? sat_sample(center_sum) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b1;
            filter_mode_reg <= 1'b0;
            gain_left_reg   <= GAIN_RST;
            gain_right_reg  <= GAIN_RST;
            limit_level_reg <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENABLE:      enable_reg      <= cfg_wdata[0];
                REG_FILTER_MODE: filter_mode_reg <= cfg_wdata[0];
                REG_GAIN_LEFT:   gain_left_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_RIGHT:  gain_right_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_LIMIT_LEVEL: limit_level_reg <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat && (s_tuser == OP_SAMPLE)) begin
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    state_reg <= ST_CLIP;
                end
                ST_CLIP: begin
                    state_reg <= run_fir ? ST_FIR : ST_FINISH;
                end
                ST_FIR: begin
                    if (fir_stat.done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && (s_tuser == OP_SAMPLE)) begin
            l_raw_reg <= in_left;
            r_raw_reg <= in_right;
        end
        if (state_reg == ST_GAIN) begin
            gp_l_reg <= l_raw_reg * $signed({1'b0, gain_left_reg});
            gp_r_reg <= r_raw_reg * $signed({1'b0, gain_right_reg});
        end
        if (state_reg == ST_CLIP) begin
            ls_reg <= ls_c;
            rs_reg <= rs_c;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_tdata_reg <= M_TDATA_W'({out_c_c, out_rs_c, out_ls_c, out_r_c, out_l_c});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `STFM_ASSERT_IMP(a_push_when_free, fir_ctrl.push,
        !fir_stat.busy && enable_reg && filter_mode_reg, "fir push while engine busy")
    `STFM_ASSERT_IMP(a_done_in_fir, fir_stat.done, state_reg == ST_FIR,
        "fir done outside the filter wait")
    `STFM_ASSERT_NXT(a_sample_holds_off, s_tvalid && s_tready && (s_tuser == OP_SAMPLE),
        !s_tready, "input taken while a sample is in work")
    `STFM_ASSERT_IMP(a_result_from_finish, $rose(m_tvalid), $past(state_reg) == ST_FINISH,
        "result beat raised outside the finish step")

endmodule
